[rtl/core/csi_pkg.sv]
// ----------------------------------------------------------------------------
// csi_pkg: carousel stepper indexer shared definitions
// Widths, ring size, register indexes, coil patterns and the move plan type.
// ----------------------------------------------------------------------------
package csi_pkg;

  // Carousel geometry
  localparam int unsigned SLOT_COUNT = 6;
  localparam int unsigned SLOT_HALF  = SLOT_COUNT / 2;
  localparam int unsigned SLOT_W     = 5;   // holds 0..31

  // Field and state widths
  localparam int unsigned OFFSET_W   = 4;
  localparam int unsigned CFG_W      = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned STEPS_W    = 10;
  localparam int unsigned PROD_W     = SLOT_W + CFG_W;
  localparam int unsigned PHASE_W    = 2;
  localparam int unsigned COIL_W     = 4;

  localparam logic [STEPS_W-1:0] STEPS_MAX = {STEPS_W{1'b1}};

  // Reset values of the configuration registers
  localparam logic [CFG_W-1:0] STEPS_PER_SLOT_RST = 8'd34;
  localparam logic [CFG_W-1:0] STEP_INTERVAL_RST  = 8'd100;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STEPS_PER_SLOT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_INTERVAL  = 2'd1;

  // Item operation codes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_MOVE = 1'b1;

  // Result of decoding one move request
  typedef struct packed {
    logic               load;     // start a motion
    logic               reverse;  // turn direction
    logic [STEPS_W-1:0] steps;    // motor steps to go
  } move_plan_t;

  // Full-step coil pattern for a phase index
  function automatic logic [COIL_W-1:0] coil_word(input logic [PHASE_W-1:0] phase);
    logic [COIL_W-1:0] word;
    case (phase)
      2'd0:    word = 4'b0101;
      2'd1:    word = 4'b1001;
      2'd2:    word = 4'b1010;
      2'd3:    word = 4'b0110;
      default: word = 4'b0101;
    endcase
    return word;
  endfunction

endpackage

[rtl/core/csi_move_plan.sv]
// ----------------------------------------------------------------------------
// csi_move_plan: move request decoder
// Picks the shorter way round the ring and sizes the step count of a move.
// ----------------------------------------------------------------------------
module csi_move_plan
  import csi_pkg::*;
(
  input  logic signed [OFFSET_W-1:0] slot_offset_i,
  input  logic        [CFG_W-1:0]    steps_per_slot_i,
  output move_plan_t                 plan_o
);

  logic                neg;
  logic [OFFSET_W-1:0] mag_raw;
  logic [SLOT_W-1:0]   mag;
  logic                in_range;
  logic                short_way;
  logic [SLOT_W-1:0]   slots;
  logic [PROD_W-1:0]   total;

  assign neg     = slot_offset_i[OFFSET_W-1];
  // most negative offset folds to its own magnitude, which is what we want
  assign mag_raw = neg ? (~slot_offset_i + 1'b1) : slot_offset_i;
  assign mag     = {1'b0, mag_raw};

  assign in_range  = (mag != '0) && (mag < SLOT_W'(SLOT_COUNT));
  assign short_way = (mag <= SLOT_W'(SLOT_HALF));
  assign slots     = short_way ? mag : (SLOT_W'(SLOT_COUNT) - mag);
  assign total     = PROD_W'(slots) * PROD_W'(steps_per_slot_i);

  always_comb begin
    plan_o.reverse = short_way ? neg : ~neg;
    // saturate the step count
    if (total > PROD_W'(STEPS_MAX)) begin
      plan_o.steps = STEPS_MAX;
    end else begin
      plan_o.steps = total[STEPS_W-1:0];
    end
    plan_o.load = in_range && (total != '0);
  end

endmodule

[rtl/core/carousel_stepper_indexer_core.sv]
// ----------------------------------------------------------------------------
// carousel_stepper_indexer_core: full-step indexer for a carousel stepper
// Turns slot moves into timed four-phase coil patterns, one result per item.
// ----------------------------------------------------------------------------
// Each accepted item (a tick or a move) yields exactly one result, registered in
// the output register; a new item is taken every clock as long as the output
// register is empty or its result is transferred in the same cycle. The whole
// update of step counter, tick counter and phase index happens in one pass of
// logic between the state registers, so the rate is one item per cycle unless
// the output stalls. Configuration writes are always ready and take effect at once.
module carousel_stepper_indexer_core
  import csi_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // item channel
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       op_i,
  input  logic signed [OFFSET_W-1:0] slot_offset_i,
  // result channel
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic        [COIL_W-1:0]   phase_word_o,
  output logic                       phase_valid_o,
  output logic                       busy_res_o,
  output logic                       move_rejected_o,
  // configuration channel
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic        [CFG_IDX_W-1:0] cfg_index_i,
  input  logic        [CFG_W-1:0]    cfg_data_i
);

  logic [CFG_W-1:0]   steps_per_slot_q;
  logic [CFG_W-1:0]   step_interval_q;
  logic [PHASE_W-1:0] phase_index_q, phase_index_d;
  logic [STEPS_W-1:0] steps_left_q, steps_left_d;
  logic               reverse_dir_q, reverse_dir_d;
  logic [CFG_W-1:0]   tick_count_q, tick_count_d;

  logic               out_valid_q;
  logic [COIL_W-1:0]  phase_word_q, phase_word_d;
  logic               phase_valid_q, phase_valid_d;
  logic               busy_q;
  logic               rejected_q, rejected_d;

  logic               in_xfer;
  logic               busy;
  logic [CFG_W:0]     tick_next;
  move_plan_t         plan;

  csi_move_plan u_move_plan (
    .slot_offset_i   (slot_offset_i),
    .steps_per_slot_i(steps_per_slot_q),
    .plan_o          (plan)
  );

  // hold input while a result waits and is not taken
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_xfer     = in_valid_i & ~in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign busy      = (steps_left_q != '0);
  assign tick_next = {1'b0, tick_count_q} + 1'b1;

  always_comb begin
    phase_index_d = phase_index_q;
    steps_left_d  = steps_left_q;
    reverse_dir_d = reverse_dir_q;
    tick_count_d  = tick_count_q;
    phase_word_d  = '0;
    phase_valid_d = 1'b0;
    rejected_d    = 1'b0;
    if (op_i == OP_MOVE) begin
      if (busy) begin
        rejected_d = 1'b1;
      end else if (plan.load) begin
        steps_left_d  = plan.steps;
        reverse_dir_d = plan.reverse;
        tick_count_d  = '0;
      end
    end else if (busy) begin
      if (tick_next >= {1'b0, step_interval_q}) begin
        phase_word_d  = coil_word(phase_index_q);
        phase_valid_d = 1'b1;
        // reverse advances the phase, forward backs it off
        phase_index_d = reverse_dir_q ? (phase_index_q + 1'b1) : (phase_index_q - 1'b1);
        steps_left_d  = steps_left_q - 1'b1;
        tick_count_d  = '0;
      end else begin
        tick_count_d  = tick_next[CFG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_per_slot_q <= STEPS_PER_SLOT_RST;
      step_interval_q  <= STEP_INTERVAL_RST;
      phase_index_q    <= '0;
      steps_left_q     <= '0;
      reverse_dir_q    <= 1'b0;
      tick_count_q     <= '0;
      out_valid_q      <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_STEPS_PER_SLOT: steps_per_slot_q <= cfg_data_i;
          REG_STEP_INTERVAL:  step_interval_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_xfer) begin
        phase_index_q <= phase_index_d;
        steps_left_q  <= steps_left_d;
        reverse_dir_q <= reverse_dir_d;
        tick_count_q  <= tick_count_d;
        out_valid_q   <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q   <= 1'b0;
      end
    end
  end

  // result payload, loaded on every input transfer
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      phase_word_q  <= phase_word_d;
      phase_valid_q <= phase_valid_d;
      busy_q        <= (steps_left_d != '0);
      rejected_q    <= rejected_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign phase_word_o    = phase_word_q;
  assign phase_valid_o   = phase_valid_q;
  assign busy_res_o      = busy_q;
  assign move_rejected_o = rejected_q;

endmodule
